@@ hw/rtl/i2cmts_pkg.sv @@
package i2cmts_pkg;

    typedef enum logic [1:0] {
        REQ_BEGIN  = 2'd0,
        REQ_WBYTE  = 2'd1,
        REQ_STATUS = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_SEND   = 3'd2,
        CMD_RDACK  = 3'd3,
        CMD_RDNACK = 3'd4,
        CMD_STOP   = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_WSTART = 4'd1,
        PH_WADDR  = 4'd2,
        PH_WWAIT  = 4'd3,
        PH_WDATA  = 4'd4,
        PH_RSTART = 4'd5,
        PH_RADDR  = 4'd6,
        PH_RACK   = 4'd7,
        PH_RNACK  = 4'd8
    } phase_t;

    localparam logic [7:0] ST_MASK    = 8'hf8;
    localparam logic [7:0] ST_START   = 8'h08;
    localparam logic [7:0] ST_RSTART  = 8'h10;
    localparam logic [7:0] ST_SLAW_OK = 8'h18;
    localparam logic [7:0] ST_SLAW_NK = 8'h20;
    localparam logic [7:0] ST_DATA_OK = 8'h28;
    localparam logic [7:0] ST_DATA_NK = 8'h30;
    localparam logic [7:0] ST_SLAR_OK = 8'h40;
    localparam logic [7:0] ST_SLAR_NK = 8'h48;
    localparam logic [7:0] ST_RD_ACK  = 8'h50;
    localparam logic [7:0] ST_RD_NACK = 8'h58;
    localparam logic [7:0] ADDR_WMASK = 8'hfe;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  device_address;
        logic [15:0] prefix_count;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [7:0]  write_byte;
        logic [7:0]  bus_status;
        logic [7:0]  received_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] command_byte;
        logic       want_write_byte;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done_res;
        logic [7:0] result_status;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  saved_address;
        logic [16:0] writes_left;
        logic [15:0] reads_left;
        logic        wrote_flag;
    } seq_state_t;

endpackage

@@ hw/rtl/i2cmts_if.sv @@
interface i2cmts_in_if
    import i2cmts_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface i2cmts_out_if
    import i2cmts_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

@@ hw/rtl/i2cmts_step.sv @@
module i2cmts_step
    import i2cmts_pkg::*;
(
    input  in_item_t   item,
    input  seq_state_t state,
    output seq_state_t state_next,
    output out_item_t  result,
    output logic       has_result
);

    logic [7:0]  status_masked;
    logic [16:0] write_sum;
    logic [15:0] reads_dec;
    logic [7:0]  read_expect;
    logic        writes_pending;
    logic        reads_pending;

    assign status_masked  = item.bus_status & ST_MASK;
    assign write_sum      = {1'b0, item.prefix_count} + {1'b0, item.write_count};
    assign reads_dec      = state.reads_left - 16'd1;
    assign read_expect    = state.wrote_flag ? ST_RSTART : ST_START;
    assign writes_pending = (state.writes_left != 17'd0);
    assign reads_pending  = (state.reads_left != 16'd0);

    // Next state.
    always_comb
    begin
        state_next = state;
        case (req_t'(item.req_type))
            REQ_BEGIN:
            begin
                if (state.phase == PH_IDLE)
                begin
                    state_next.saved_address = item.device_address;
                    state_next.writes_left   = write_sum;
                    state_next.reads_left    = item.read_count;
                    if (write_sum != 17'd0)
                    begin
                        state_next.wrote_flag = 1'b1;
                        state_next.phase      = PH_WSTART;
                    end
                    else if (item.read_count != 16'd0)
                    begin
                        state_next.wrote_flag = 1'b0;
                        state_next.phase      = PH_RSTART;
                    end
                    else
                    begin
                        state_next.wrote_flag = 1'b0;
                        state_next.phase      = PH_IDLE;
                    end
                end
            end
            REQ_WBYTE:
            begin
                if (state.phase == PH_WWAIT)
                begin
                    state_next.writes_left = state.writes_left - 17'd1;
                    state_next.phase       = PH_WDATA;
                end
            end
            REQ_STATUS:
            begin
                case (state.phase)
                    PH_WSTART:
                        state_next.phase = (status_masked == ST_START) ? PH_WADDR : PH_IDLE;
                    PH_WADDR, PH_WDATA:
                    begin
                        if ((state.phase == PH_WADDR && status_masked == ST_SLAW_OK) ||
                            (state.phase == PH_WDATA && status_masked == ST_DATA_OK))
                        begin
                            if (writes_pending)
                                state_next.phase = PH_WWAIT;
                            else if (reads_pending)
                                state_next.phase = PH_RSTART;
                            else
                                state_next.phase = PH_IDLE;
                        end
                        else
                            state_next.phase = PH_IDLE;
                    end
                    PH_RSTART:
                        state_next.phase = (status_masked == read_expect) ? PH_RADDR : PH_IDLE;
                    PH_RADDR:
                    begin
                        if (status_masked == ST_SLAR_OK)
                        begin
                            state_next.reads_left = reads_dec;
                            state_next.phase      = (reads_dec != 16'd0) ? PH_RACK : PH_RNACK;
                        end
                        else
                            state_next.phase = PH_IDLE;
                    end
                    PH_RACK:
                    begin
                        if (status_masked == ST_RD_ACK)
                        begin
                            state_next.reads_left = reads_dec;
                            if (reads_dec == 16'd0)
                                state_next.phase = PH_RNACK;
                        end
                        else
                            state_next.phase = PH_IDLE;
                    end
                    PH_RNACK:
                        state_next.phase = PH_IDLE;
                    default:
                        state_next = state;
                endcase
            end
            default:
                state_next = state;
        endcase
    end

    // Result item.
    always_comb
    begin
        result     = '0;
        has_result = 1'b0;
        case (req_t'(item.req_type))
            REQ_BEGIN:
            begin
                if (state.phase == PH_IDLE)
                begin
                    has_result = 1'b1;
                    if (write_sum != 17'd0 || item.read_count != 16'd0)
                        result.bus_command = CMD_START;
                    else
                        result.done_res = 1'b1;
                end
            end
            REQ_WBYTE:
            begin
                if (state.phase == PH_WWAIT)
                begin
                    has_result          = 1'b1;
                    result.bus_command  = CMD_SEND;
                    result.command_byte = item.write_byte;
                end
            end
            REQ_STATUS:
            begin
                has_result = 1'b1;
                case (state.phase)
                    PH_WSTART:
                    begin
                        if (status_masked == ST_START)
                        begin
                            result.bus_command  = CMD_SEND;
                            result.command_byte = state.saved_address & ADDR_WMASK;
                        end
                        else
                        begin
                            result.done_res      = 1'b1;
                            result.result_status = status_masked;
                        end
                    end
                    PH_WADDR, PH_WDATA:
                    begin
                        if ((state.phase == PH_WADDR && status_masked == ST_SLAW_OK) ||
                            (state.phase == PH_WDATA && status_masked == ST_DATA_OK))
                        begin
                            if (writes_pending)
                                result.want_write_byte = 1'b1;
                            else if (reads_pending)
                                result.bus_command = CMD_START;
                            else
                            begin
                                result.bus_command = CMD_STOP;
                                result.done_res    = 1'b1;
                            end
                        end
                        else if ((state.phase == PH_WADDR && status_masked == ST_SLAW_NK) ||
                                 (state.phase == PH_WDATA && status_masked == ST_DATA_NK))
                        begin
                            // The device refused: release the bus before reporting.
                            result.bus_command   = CMD_STOP;
                            result.done_res      = 1'b1;
                            result.result_status = status_masked;
                        end
                        else
                        begin
                            result.done_res      = 1'b1;
                            result.result_status = status_masked;
                        end
                    end
                    PH_RSTART:
                    begin
                        if (status_masked == read_expect)
                        begin
                            result.bus_command  = CMD_SEND;
                            result.command_byte = state.saved_address | 8'h01;
                        end
                        else
                        begin
                            result.done_res      = 1'b1;
                            result.result_status = status_masked;
                        end
                    end
                    PH_RADDR:
                    begin
                        if (status_masked == ST_SLAR_OK)
                            result.bus_command = (reads_dec != 16'd0) ? CMD_RDACK : CMD_RDNACK;
                        else if (status_masked == ST_SLAR_NK)
                        begin
                            result.bus_command   = CMD_STOP;
                            result.done_res      = 1'b1;
                            result.result_status = status_masked;
                        end
                        else
                        begin
                            result.done_res      = 1'b1;
                            result.result_status = status_masked;
                        end
                    end
                    PH_RACK:
                    begin
                        if (status_masked == ST_RD_ACK)
                        begin
                            result.read_byte   = item.received_byte;
                            result.read_valid  = 1'b1;
                            result.bus_command = (reads_dec != 16'd0) ? CMD_RDACK : CMD_RDNACK;
                        end
                        else
                        begin
                            result.done_res      = 1'b1;
                            result.result_status = status_masked;
                        end
                    end
                    PH_RNACK:
                    begin
                        if (status_masked == ST_RD_NACK)
                        begin
                            result.read_byte   = item.received_byte;
                            result.read_valid  = 1'b1;
                            result.bus_command = CMD_STOP;
                            result.done_res    = 1'b1;
                        end
                        else
                        begin
                            result.done_res      = 1'b1;
                            result.result_status = status_masked;
                        end
                    end
                    default:
                        has_result = 1'b0;
                endcase
            end
            default:
                has_result = 1'b0;
        endcase
    end

endmodule

@@ hw/rtl/i2c_master_transaction_sequencer.sv @@
// Write-then-read transaction sequencer for a byte-level I2C bus engine.
// Requests arrive as items on in_ch: a begin item carrying the device
// address and the prefix, write and read counts, a write-byte item when the
// block has asked for the next byte, and a status item after every bus
// command. Each accepted item that fits the current phase yields one item on
// out_ch with the next bus command, a write-byte request, a received byte
// or the final status; items that do not fit the phase are dropped.
// An accepted item lands in the input register; the step logic works on it
// combinationally and the result is registered in the output register, from
// which out_ch presents it until it is taken.
// One item is taken every cycle while out_ch keeps up.
// When out_ch stalls, the pending result is held in the output register and
// the item behind it waits in the input register; in_ch.ready drops only
// when both are occupied.
// Reset clears the phase to idle, the saved address, both counters and the
// wrote flag, and empties both registers.
module i2c_master_transaction_sequencer
    import i2cmts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    i2cmts_in_if.sink           in_ch,
    i2cmts_out_if.source        out_ch
);

    in_item_t   in_item_reg;
    logic       in_valid_reg;
    out_item_t  out_item_reg;
    logic       out_valid_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    out_item_t  step_result;
    logic       step_has_result;
    logic       advance;

    i2cmts_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result),
        .has_result (step_has_result)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, saved_address: 8'd0, writes_left: 17'd0,
                               reads_left: 16'd0, wrote_flag: 1'b0};
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= step_has_result;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            in_item_reg <= in_ch.item;
        if (advance && step_has_result)
            out_item_reg <= step_result;
    end

endmodule

@@ sim/i2cmts_txn_checker.sv @@
module i2cmts_txn_checker
    import i2cmts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  in_item_t  req_item,
    input  logic      res_valid,
    input  logic      res_ready,
    input  out_item_t res_item,
    output int        errors,
    output int        outstanding
);

    phase_t      phase;
    logic [7:0]  dev_addr;
    logic [16:0] writes_left;
    logic [15:0] reads_left;
    logic        wrote;
    out_item_t   awaited[$];
    out_item_t   predicted;
    out_item_t   want;
    bit          produced;

    task automatic report_error(input string msg);
        $display("%0t checker: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] exp_val);
        if (got !== exp_val)
            report_error($sformatf("%s is %h, expected %h", name, got, exp_val));
    endtask

    task automatic close_txn(inout out_item_t r, input cmd_t cmd, input logic [7:0] st);
        r.bus_command   = cmd;
        r.done_res      = 1'b1;
        r.result_status = st;
        phase           = PH_IDLE;
    endtask

    // Advances the shadow sequencer by one item and works out the result it gives.
    task automatic step_sequencer(input in_item_t it, output bit gives, output out_item_t r);
        logic [7:0] st;
        logic [7:0] ok_code;
        logic [7:0] nak_code;
        st = it.bus_status & ST_MASK;
        r = '0;
        gives = 1'b0;
        case (req_t'(it.req_type))
            REQ_BEGIN:
            begin
                if (phase == PH_IDLE)
                begin
                    gives       = 1'b1;
                    dev_addr    = it.device_address;
                    writes_left = {1'b0, it.prefix_count} + {1'b0, it.write_count};
                    reads_left  = it.read_count;
                    wrote       = (writes_left != 0);
                    if (writes_left != 0)
                    begin
                        r.bus_command = CMD_START;
                        phase = PH_WSTART;
                    end
                    else if (reads_left != 0)
                    begin
                        r.bus_command = CMD_START;
                        phase = PH_RSTART;
                    end
                    else
                        close_txn(r, CMD_NONE, 8'h00);
                end
            end
            REQ_WBYTE:
            begin
                if (phase == PH_WWAIT)
                begin
                    gives          = 1'b1;
                    r.bus_command  = CMD_SEND;
                    r.command_byte = it.write_byte;
                    writes_left    = writes_left - 17'd1;
                    phase          = PH_WDATA;
                end
            end
            REQ_STATUS:
            begin
                gives = 1'b1;
                case (phase)
                    PH_WSTART:
                    begin
                        if (st != ST_START)
                            close_txn(r, CMD_NONE, st);
                        else
                        begin
                            r.bus_command  = CMD_SEND;
                            r.command_byte = dev_addr & ADDR_WMASK;
                            phase = PH_WADDR;
                        end
                    end
                    PH_WADDR, PH_WDATA:
                    begin
                        ok_code  = (phase == PH_WADDR) ? ST_SLAW_OK : ST_DATA_OK;
                        nak_code = (phase == PH_WADDR) ? ST_SLAW_NK : ST_DATA_NK;
                        if (st == ok_code)
                        begin
                            if (writes_left != 0)
                            begin
                                r.want_write_byte = 1'b1;
                                phase = PH_WWAIT;
                            end
                            else if (reads_left != 0)
                            begin
                                r.bus_command = CMD_START;
                                phase = PH_RSTART;
                            end
                            else
                                close_txn(r, CMD_STOP, 8'h00);
                        end
                        else if (st == nak_code)
                            close_txn(r, CMD_STOP, st);
                        else
                            close_txn(r, CMD_NONE, st);
                    end
                    PH_RSTART:
                    begin
                        // After writing, the bus engine reports a repeated start.
                        if (st != (wrote ? ST_RSTART : ST_START))
                            close_txn(r, CMD_NONE, st);
                        else
                        begin
                            r.bus_command  = CMD_SEND;
                            r.command_byte = dev_addr | 8'h01;
                            phase = PH_RADDR;
                        end
                    end
                    PH_RADDR:
                    begin
                        if (st == ST_SLAR_OK)
                        begin
                            reads_left = reads_left - 16'd1;
                            if (reads_left != 0)
                            begin
                                r.bus_command = CMD_RDACK;
                                phase = PH_RACK;
                            end
                            else
                            begin
                                r.bus_command = CMD_RDNACK;
                                phase = PH_RNACK;
                            end
                        end
                        else if (st == ST_SLAR_NK)
                            close_txn(r, CMD_STOP, st);
                        else
                            close_txn(r, CMD_NONE, st);
                    end
                    PH_RACK:
                    begin
                        if (st != ST_RD_ACK)
                            close_txn(r, CMD_NONE, st);
                        else
                        begin
                            r.read_byte  = it.received_byte;
                            r.read_valid = 1'b1;
                            reads_left   = reads_left - 16'd1;
                            if (reads_left != 0)
                                r.bus_command = CMD_RDACK;
                            else
                            begin
                                r.bus_command = CMD_RDNACK;
                                phase = PH_RNACK;
                            end
                        end
                    end
                    PH_RNACK:
                    begin
                        if (st != ST_RD_NACK)
                            close_txn(r, CMD_NONE, st);
                        else
                        begin
                            r.read_byte  = it.received_byte;
                            r.read_valid = 1'b1;
                            close_txn(r, CMD_STOP, 8'h00);
                        end
                    end
                    default:
                        gives = 1'b0;
                endcase
            end
            default:
                gives = 1'b0;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase       = PH_IDLE;
            dev_addr    = '0;
            writes_left = '0;
            reads_left  = '0;
            wrote       = 1'b0;
            awaited.delete();
            outstanding = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                step_sequencer(req_item, produced, predicted);
                if (produced)
                    awaited.push_back(predicted);
            end
            if (res_valid && res_ready)
            begin
                if (awaited.size() == 0)
                    report_error("result item arrived with none expected");
                else
                begin
                    want = awaited.pop_front();
                    compare_field("bus_command", 16'(res_item.bus_command),
                                  16'(want.bus_command));
                    compare_field("command_byte", 16'(res_item.command_byte),
                                  16'(want.command_byte));
                    compare_field("want_write_byte", 16'(res_item.want_write_byte),
                                  16'(want.want_write_byte));
                    compare_field("read_byte", 16'(res_item.read_byte),
                                  16'(want.read_byte));
                    compare_field("read_valid", 16'(res_item.read_valid),
                                  16'(want.read_valid));
                    compare_field("done_res", 16'(res_item.done_res),
                                  16'(want.done_res));
                    compare_field("result_status", 16'(res_item.result_status),
                                  16'(want.result_status));
                end
            end
            outstanding = awaited.size();
        end
    end

endmodule

@@ sim/tb.sv @@
module tb;
    import i2cmts_pkg::*;

    typedef enum {AT_IDLE, AT_BUSY, AT_BYTE} spot_t;

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle;
    int   sink_idle;
    bit   hold_req;
    int   hold_count;
    int   items_sent;
    int   checker_errors;
    int   results_owed;
    int   step_no;
    int   abort_at;
    int   step_cap;
    int   err_pct;
    int   noise_pct;
    bit   abort_nak;
    bit   stalled;
    bit   drained;

    i2cmts_in_if  in_ch ();
    i2cmts_out_if out_ch ();

    i2c_master_transaction_sequencer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    i2cmts_txn_checker txn_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (in_ch.valid),
        .req_ready   (in_ch.ready),
        .req_item    (in_ch.item),
        .res_valid   (out_ch.valid),
        .res_ready   (out_ch.ready),
        .res_item    (out_ch.item),
        .errors      (checker_errors),
        .outstanding (results_owed)
    );

    always #4 clk = ~clk;

    initial
    begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold-off counted here when asked.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                hold_count++;
                if (hold_count == 300)
                begin
                    hold_req   = 1'b0;
                    hold_count = 0;
                end
            end
            else
                out_ch.ready <= ($urandom_range(99) >= sink_idle);
        end
    end

    function automatic in_item_t any_item();
        in_item_t it;
        it.req_type       = 2'($urandom_range(3));
        it.device_address = 8'($urandom_range(255));
        it.prefix_count   = 16'($urandom_range(65535));
        it.write_count    = 16'($urandom_range(65535));
        it.read_count     = 16'($urandom_range(65535));
        it.write_byte     = 8'($urandom_range(255));
        it.bus_status     = 8'($urandom_range(255));
        it.received_byte  = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 16'd0;
        if (r < 85)
            return 16'($urandom_range(3, 1));
        if (r < 95)
            return 16'($urandom_range(12, 4));
        return 16'($urandom_range(65535));
    endfunction

    // Valid stays high after acceptance until the next call lowers it or
    // offers a new item, so each clock step sees one assignment at most.
    task automatic send_item(input in_item_t it, input bit counted);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (counted)
            items_sent++;
    endtask

    // An item of a kind that the block must drop in its present phase.
    task automatic maybe_noise(input spot_t spot);
        in_item_t it;
        int       pick;
        if ($urandom_range(99) >= noise_pct)
            return;
        it = any_item();
        pick = $urandom_range(2);
        if (pick == 0)
            it.req_type = REQ_UNUSED;
        else
            case (spot)
                AT_IDLE: it.req_type = (pick == 1) ? REQ_WBYTE : REQ_STATUS;
                AT_BUSY: it.req_type = (pick == 1) ? REQ_WBYTE : REQ_BEGIN;
                default: it.req_type = (pick == 1) ? REQ_STATUS : REQ_BEGIN;
            endcase
        send_item(it, 1'b0);
    endtask

    task automatic status_step(input logic [7:0] good, input logic [7:0] nak, output bit go);
        in_item_t it;
        bit       fail;
        step_no++;
        maybe_noise(AT_BUSY);
        it = any_item();
        it.req_type = REQ_STATUS;
        fail = (step_no == abort_at) || (step_no > step_cap) || ($urandom_range(99) < err_pct);
        if (!fail)
            it.bus_status = good | 8'($urandom_range(7));
        else if (nak != 8'h00 && (abort_nak || $urandom_range(1) == 1))
            it.bus_status = nak | 8'($urandom_range(7));
        else
            while ((it.bus_status & ST_MASK) == good)
                it.bus_status = 8'($urandom_range(255));
        send_item(it, 1'b1);
        go = !fail;
    endtask

    // Plays the bus engine's side of one transaction, aborting where a status goes wrong.
    task automatic run_transaction(input logic [7:0] addr, input logic [15:0] pc,
                                   input logic [15:0] wc, input logic [15:0] rc);
        in_item_t it;
        int       wleft;
        int       rleft;
        bit       wrote;
        bit       go;
        step_no = 0;
        maybe_noise(AT_IDLE);
        it = any_item();
        it.req_type       = REQ_BEGIN;
        it.device_address = addr;
        it.prefix_count   = pc;
        it.write_count    = wc;
        it.read_count     = rc;
        send_item(it, 1'b1);
        wleft = int'(pc) + int'(wc);
        rleft = int'(rc);
        wrote = (wleft > 0);
        if (wleft > 0)
        begin
            status_step(ST_START, 8'h00, go);
            if (!go)
                return;
            status_step(ST_SLAW_OK, ST_SLAW_NK, go);
            if (!go)
                return;
            while (wleft > 0)
            begin
                maybe_noise(AT_BYTE);
                it = any_item();
                it.req_type = REQ_WBYTE;
                send_item(it, 1'b1);
                wleft--;
                status_step(ST_DATA_OK, ST_DATA_NK, go);
                if (!go)
                    return;
            end
        end
        if (rleft > 0)
        begin
            status_step(wrote ? ST_RSTART : ST_START, 8'h00, go);
            if (!go)
                return;
            status_step(ST_SLAR_OK, ST_SLAR_NK, go);
            if (!go)
                return;
            rleft--;
            while (rleft > 0)
            begin
                status_step(ST_RD_ACK, 8'h00, go);
                if (!go)
                    return;
                rleft--;
            end
            status_step(ST_RD_NACK, 8'h00, go);
        end
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (results_owed != 0);
        @(posedge clk);
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.item  = '0;
        rst_n       = 1'b0;
        src_idle    = 24;
        sink_idle   = 56;
        noise_pct   = 0;
        err_pct     = 0;
        step_cap    = 1 << 30;
        abort_at    = -1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_transaction(8'h00, 16'd0, 16'd0, 16'd0);
        // Largest counts; a data NAK on the second byte cuts it short.
        abort_nak = 1'b1;
        abort_at  = 4;
        run_transaction(8'hff, 16'hffff, 16'hffff, 16'hffff);
        abort_at = -1;
        run_transaction(8'ha5, 16'd0, 16'd0, 16'd2);
        run_transaction(8'h5a, 16'd1, 16'd0, 16'd1);
        abort_at = 2;
        run_transaction(8'h3c, 16'd0, 16'd1, 16'd0);
        abort_nak = 1'b0;
        abort_at  = 1;
        run_transaction(8'hc3, 16'd0, 16'd0, 16'hffff);
        noise_pct = 100;
        maybe_noise(AT_IDLE);
        maybe_noise(AT_IDLE);

        abort_at  = -1;
        noise_pct = 5;
        err_pct   = 3;
        step_cap  = 40;
        while (items_sent < 1400)
        begin
            if (items_sent >= 940)
            begin
                src_idle  = 0;
                sink_idle = 0;
            end
            else if (items_sent >= 470)
            begin
                src_idle  = 56;
                sink_idle = 24;
            end
            if (!stalled && items_sent >= 200)
            begin
                stalled  = 1'b1;
                hold_req = 1'b1;
            end
            if (!drained && items_sent >= 700)
            begin
                drained = 1'b1;
                wait_for_results();
            end
            run_transaction(8'($urandom_range(255)), pick_count(), pick_count(), pick_count());
        end

        wait_for_results();
        repeat (20) @(negedge clk);
        if (checker_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
